// File: design/bmhq_pkg.sv
// Shared constants, codes and types of the binary min-heap queue unit.
package bmhq_pkg;

   localparam int HEAP_DEPTH = 64;
   localparam int VALUE_BITS = 16;

   localparam int PRIO_BITS  = 16;
   localparam int OCC_BITS   = 7;
   localparam int IDX_BITS   = $clog2(HEAP_DEPTH);
   localparam int CNT_BITS   = $clog2(HEAP_DEPTH + 1);
   localparam int CHILD_BITS = IDX_BITS + 2;

   localparam logic REQ_INSERT  = 1'b0;
   localparam logic REQ_EXTRACT = 1'b1;

   typedef enum logic [1:0] {
      ST_INSERTED  = 2'd0,
      ST_EXTRACTED = 2'd1,
      ST_FULL      = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_UP_READ,
      S_UP_TEST,
      S_DN_ROOT,
      S_DN_LAST,
      S_DN_RIGHT,
      S_DN_PICK,
      S_DN_TEST,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic                  wr_en;
      logic [IDX_BITS-1:0]   wr_addr;
      logic [VALUE_BITS-1:0] wr_data;
      logic [IDX_BITS-1:0]   rd_addr;
   } ram_req_type;

endpackage

// File: design/bmhq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bmhq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/bmhq_core.sv
// Sequencer and datapath of the heap queue with one shared value comparator.
module bmhq_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           req_type,
   input  logic [bmhq_pkg::PRIO_BITS-1:0] req_job_priority,
   input  logic [bmhq_pkg::VALUE_BITS-1:0] rd_data,
   output bmhq_pkg::ram_req_type          ram_req,
   output logic                           busy,
   output logic                           rsp_valid,
   output logic [bmhq_pkg::PRIO_BITS-1:0] rsp_min_value,
   output logic [1:0]                     rsp_status,
   output logic [bmhq_pkg::OCC_BITS-1:0]  rsp_occupancy
);

   bmhq_pkg::state_type state_ff, state_in;
   logic [bmhq_pkg::IDX_BITS-1:0]   pos_ff, pos_in;
   logic [bmhq_pkg::VALUE_BITS-1:0] val_ff, val_in;
   logic [bmhq_pkg::CNT_BITS-1:0]   count_ff, count_in;
   logic [bmhq_pkg::VALUE_BITS-1:0] min_ff, min_in;
   logic [bmhq_pkg::VALUE_BITS-1:0] left_val_ff, left_val_in;
   logic                            right_ok_ff, right_ok_in;
   logic [bmhq_pkg::VALUE_BITS-1:0] pick_val_ff, pick_val_in;
   logic [bmhq_pkg::IDX_BITS-1:0]   pick_idx_ff, pick_idx_in;
   logic                            ext_ff, ext_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   bmhq_pkg::status_type            status_ff, status_in;

   logic [bmhq_pkg::VALUE_BITS-1:0] cmp_a, cmp_b;
   logic                            cmp_le;
   logic [bmhq_pkg::IDX_BITS-1:0]   pos_dec, parent;
   logic [bmhq_pkg::CNT_BITS-1:0]   cnt_dec;
   logic [bmhq_pkg::IDX_BITS-1:0]   desc_pos;
   logic [bmhq_pkg::CHILD_BITS-1:0] desc_left, cur_left, cur_right, cnt_ext;
   logic                            desc_stop, is_full, is_empty;

   // The one comparator; its operands follow the sequencer state.
   always_comb begin
      cmp_a = val_ff;
      cmp_b = rd_data;
      unique case (state_ff)
         bmhq_pkg::S_DN_PICK: begin
            cmp_a = left_val_ff;
            cmp_b = rd_data;
         end
         bmhq_pkg::S_DN_TEST: begin
            cmp_a = val_ff;
            cmp_b = pick_val_ff;
         end
         default: begin
            cmp_a = val_ff;
            cmp_b = rd_data;
         end
      endcase
   end

   assign cmp_le    = (cmp_a <= cmp_b);
   assign pos_dec   = pos_ff - 1'b1;
   assign parent    = {1'b0, pos_dec[bmhq_pkg::IDX_BITS-1:1]};
   assign cnt_dec   = count_ff - 1'b1;
   assign cnt_ext   = bmhq_pkg::CHILD_BITS'(count_ff);
   assign desc_pos  = (state_ff == bmhq_pkg::S_DN_TEST) ? pick_idx_ff : '0;
   assign desc_left = {1'b0, desc_pos, 1'b1};
   assign desc_stop = (desc_left >= cnt_ext);
   assign cur_left  = {1'b0, pos_ff, 1'b1};
   assign cur_right = {1'b0, pos_ff, 1'b0} + bmhq_pkg::CHILD_BITS'(2);
   assign is_full   = (count_ff == bmhq_pkg::CNT_BITS'(bmhq_pkg::HEAP_DEPTH));
   assign is_empty  = (count_ff == '0);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bmhq_pkg::S_IDLE: begin
            if (start) begin
               if (req_type == bmhq_pkg::REQ_INSERT) begin
                  if (is_full) begin
                     state_in = bmhq_pkg::S_IDLE;
                  end else if (is_empty) begin
                     state_in = bmhq_pkg::S_FINISH;
                  end else begin
                     state_in = bmhq_pkg::S_UP_READ;
                  end
               end else if (is_empty) begin
                  state_in = bmhq_pkg::S_IDLE;
               end else begin
                  state_in = bmhq_pkg::S_DN_ROOT;
               end
            end
         end
         bmhq_pkg::S_UP_READ: state_in = bmhq_pkg::S_UP_TEST;
         bmhq_pkg::S_UP_TEST: begin
            if (cmp_le && parent != '0) begin
               state_in = bmhq_pkg::S_UP_READ;
            end else begin
               state_in = bmhq_pkg::S_FINISH;
            end
         end
         bmhq_pkg::S_DN_ROOT: state_in = bmhq_pkg::S_DN_LAST;
         bmhq_pkg::S_DN_LAST: begin
            state_in = desc_stop ? bmhq_pkg::S_FINISH : bmhq_pkg::S_DN_RIGHT;
         end
         bmhq_pkg::S_DN_RIGHT: state_in = bmhq_pkg::S_DN_PICK;
         bmhq_pkg::S_DN_PICK:  state_in = bmhq_pkg::S_DN_TEST;
         bmhq_pkg::S_DN_TEST: begin
            if (cmp_le || desc_stop) begin
               state_in = bmhq_pkg::S_FINISH;
            end else begin
               state_in = bmhq_pkg::S_DN_RIGHT;
            end
         end
         bmhq_pkg::S_FINISH: state_in = bmhq_pkg::S_IDLE;
         default: state_in = bmhq_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      pos_in       = pos_ff;
      val_in       = val_ff;
      count_in     = count_ff;
      min_in       = min_ff;
      left_val_in  = left_val_ff;
      right_ok_in  = right_ok_ff;
      pick_val_in  = pick_val_ff;
      pick_idx_in  = pick_idx_ff;
      ext_in       = ext_ff;
      rsp_valid_in = 1'b0;
      status_in    = status_ff;
      ram_req.wr_en   = 1'b0;
      ram_req.wr_addr = pos_ff;
      ram_req.wr_data = val_ff;
      ram_req.rd_addr = '0;
      unique case (state_ff)
         bmhq_pkg::S_IDLE: begin
            if (start) begin
               min_in = '0;
               ext_in = req_type;
               if (req_type == bmhq_pkg::REQ_INSERT) begin
                  if (is_full) begin
                     rsp_valid_in = 1'b1;
                     status_in    = bmhq_pkg::ST_FULL;
                  end else begin
                     val_in   = bmhq_pkg::VALUE_BITS'(req_job_priority);
                     pos_in   = count_ff[bmhq_pkg::IDX_BITS-1:0];
                     count_in = count_ff + 1'b1;
                  end
               end else if (is_empty) begin
                  rsp_valid_in = 1'b1;
                  status_in    = bmhq_pkg::ST_EMPTY;
               end
            end
         end
         bmhq_pkg::S_UP_READ: begin
            ram_req.rd_addr = parent;
         end
         bmhq_pkg::S_UP_TEST: begin
            if (cmp_le) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_data = rd_data;
               pos_in          = parent;
            end
         end
         bmhq_pkg::S_DN_ROOT: begin
            min_in          = rd_data;
            ram_req.rd_addr = cnt_dec[bmhq_pkg::IDX_BITS-1:0];
            count_in        = cnt_dec;
         end
         bmhq_pkg::S_DN_LAST: begin
            val_in          = rd_data;
            pos_in          = desc_pos;
            ram_req.rd_addr = desc_left[bmhq_pkg::IDX_BITS-1:0];
         end
         bmhq_pkg::S_DN_RIGHT: begin
            left_val_in     = rd_data;
            ram_req.rd_addr = cur_right[bmhq_pkg::IDX_BITS-1:0];
            right_ok_in     = (cur_right < cnt_ext);
         end
         bmhq_pkg::S_DN_PICK: begin
            if (right_ok_ff && !cmp_le) begin
               pick_val_in = rd_data;
               pick_idx_in = cur_right[bmhq_pkg::IDX_BITS-1:0];
            end else begin
               pick_val_in = left_val_ff;
               pick_idx_in = cur_left[bmhq_pkg::IDX_BITS-1:0];
            end
         end
         bmhq_pkg::S_DN_TEST: begin
            if (!cmp_le) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_data = pick_val_ff;
               pos_in          = desc_pos;
               ram_req.rd_addr = desc_left[bmhq_pkg::IDX_BITS-1:0];
            end
         end
         bmhq_pkg::S_FINISH: begin
            ram_req.wr_en = 1'b1;
            rsp_valid_in  = 1'b1;
            status_in     = ext_ff ? bmhq_pkg::ST_EXTRACTED : bmhq_pkg::ST_INSERTED;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bmhq_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      val_ff      <= val_in;
      min_ff      <= min_in;
      left_val_ff <= left_val_in;
      right_ok_ff <= right_ok_in;
      pick_val_ff <= pick_val_in;
      pick_idx_ff <= pick_idx_in;
      ext_ff      <= ext_in;
      status_ff   <= status_in;
   end

   assign busy          = (state_ff != bmhq_pkg::S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_min_value = bmhq_pkg::PRIO_BITS'(min_ff);
   assign rsp_status    = status_ff;
   assign rsp_occupancy = bmhq_pkg::OCC_BITS'(count_ff);

endmodule

// File: design/binary_min_heap_queue_unit.sv
// Top level of the binary min-heap priority queue: sequencer core and heap RAM.
//
//   Channel   Ports                                  Handshake
//   request   req_type, req_job_priority             start high while busy low
//   result    rsp_min_value, rsp_status,             rsp_valid high for one cycle
//             rsp_occupancy
//
// Insert: busy while the new value climbs, with one compare per parent passed.
// Extract: busy while the last entry sinks from the root, one child level at a time.
// Each compare waits on the single registered read port of the heap RAM.
// The result shows in the first cycle with busy low again; a rejected request
// never raises busy and its result shows in the cycle after it is accepted.
// Reset clears state, entry count and result strobe. The receiver cannot stall.
module binary_min_heap_queue_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_type,
   input  logic [bmhq_pkg::PRIO_BITS-1:0] req_job_priority,
   output logic                           rsp_valid,
   output logic [bmhq_pkg::PRIO_BITS-1:0] rsp_min_value,
   output logic [1:0]                     rsp_status,
   output logic [bmhq_pkg::OCC_BITS-1:0]  rsp_occupancy
);

   bmhq_pkg::ram_req_type           ram_req;
   logic [bmhq_pkg::VALUE_BITS-1:0] rd_data;

   bmhq_core u_core (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .req_type         (req_type),
      .req_job_priority (req_job_priority),
      .rd_data          (rd_data),
      .ram_req          (ram_req),
      .busy             (busy),
      .rsp_valid        (rsp_valid),
      .rsp_min_value    (rsp_min_value),
      .rsp_status       (rsp_status),
      .rsp_occupancy    (rsp_occupancy)
   );

   bmhq_ram #(
      .WIDTH (bmhq_pkg::VALUE_BITS),
      .DEPTH (bmhq_pkg::HEAP_DEPTH)
   ) u_heap_ram (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_addr (ram_req.rd_addr),
      .rd_data (rd_data)
   );

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while a request is still in progress");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == bmhq_pkg::ST_EMPTY) |-> (rsp_occupancy == '0))
      else $error("empty rejection with a nonzero occupancy");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == bmhq_pkg::ST_FULL) |->
      (rsp_occupancy == bmhq_pkg::OCC_BITS'(bmhq_pkg::HEAP_DEPTH)))
      else $error("full rejection below capacity");

   a_min_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != bmhq_pkg::ST_EXTRACTED) |-> (rsp_min_value == '0))
      else $error("nonzero minimum on a result that is not an extract");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_occupancy <= bmhq_pkg::OCC_BITS'(bmhq_pkg::HEAP_DEPTH))
      else $error("occupancy beyond capacity");

endmodule

// File: dv/tb_binary_min_heap_queue_unit.sv
// Self-checking testbench for the binary min-heap queue unit against a shadow heap.
`timescale 1ns / 100ps

module tb_binary_min_heap_queue_unit;

   typedef struct {
      logic                           kind;
      logic [bmhq_pkg::PRIO_BITS-1:0] value;
      int                             idle_pct;
      bit                             drain_first;
   } heap_request_type;

   typedef struct {
      logic [bmhq_pkg::PRIO_BITS-1:0] min_value;
      bmhq_pkg::status_type           status;
      logic [bmhq_pkg::OCC_BITS-1:0]  occupancy;
   } heap_result_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic                           busy;
   logic                           req_type = bmhq_pkg::REQ_INSERT;
   logic [bmhq_pkg::PRIO_BITS-1:0] req_job_priority = '0;
   logic                           rsp_valid;
   logic [bmhq_pkg::PRIO_BITS-1:0] rsp_min_value;
   logic [1:0]                     rsp_status;
   logic [bmhq_pkg::OCC_BITS-1:0]  rsp_occupancy;

   heap_request_type                heap_requests_pending[$];
   heap_result_type                 heap_results_due[$];
   logic [bmhq_pkg::VALUE_BITS-1:0] shadow_heap[bmhq_pkg::HEAP_DEPTH];
   int                              shadow_count = 0;
   int                              gen_count = 0;
   int                              gen_idle_pct = 0;
   int                              mismatch_count = 0;
   int                              drain_pauses = 0;
   int                              status_tally[4] = '{0, 0, 0, 0};

   binary_min_heap_queue_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_job_priority (req_job_priority),
      .rsp_valid        (rsp_valid),
      .rsp_min_value    (rsp_min_value),
      .rsp_status       (rsp_status),
      .rsp_occupancy    (rsp_occupancy)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [bmhq_pkg::PRIO_BITS-1:0] pick_value();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2, 3, 4: return bmhq_pkg::PRIO_BITS'($urandom_range(7));
         5: return bmhq_pkg::PRIO_BITS'(16'h8000 | $urandom_range(15));
         default: return bmhq_pkg::PRIO_BITS'($urandom);
      endcase
   endfunction

   task automatic add_request(input logic kind,
                              input logic [bmhq_pkg::PRIO_BITS-1:0] value,
                              input bit drain_first);
      heap_request_type rq;
      rq.kind        = kind;
      rq.value       = value;
      rq.idle_pct    = gen_idle_pct;
      rq.drain_first = drain_first;
      heap_requests_pending.push_back(rq);
      if (kind == bmhq_pkg::REQ_INSERT && gen_count < bmhq_pkg::HEAP_DEPTH) gen_count++;
      else if (kind == bmhq_pkg::REQ_EXTRACT && gen_count > 0) gen_count--;
   endtask

   task automatic apply_to_shadow_heap(input heap_request_type rq);
      heap_result_type                 res;
      int                              pos;
      int                              parent;
      int                              left;
      int                              pick;
      bit                              sifting;
      logic [bmhq_pkg::VALUE_BITS-1:0] tmp;
      res.min_value = '0;
      if (rq.kind == bmhq_pkg::REQ_INSERT) begin
         if (shadow_count >= bmhq_pkg::HEAP_DEPTH) begin
            res.status = bmhq_pkg::ST_FULL;
         end else begin
            shadow_heap[shadow_count] = rq.value[bmhq_pkg::VALUE_BITS-1:0];
            pos = shadow_count;
            shadow_count++;
            sifting = 1'b1;
            while (sifting && pos > 0) begin
               parent = (pos - 1) / 2;
               if (shadow_heap[pos] <= shadow_heap[parent]) begin
                  tmp = shadow_heap[pos];
                  shadow_heap[pos] = shadow_heap[parent];
                  shadow_heap[parent] = tmp;
                  pos = parent;
               end else begin
                  sifting = 1'b0;
               end
            end
            res.status = bmhq_pkg::ST_INSERTED;
         end
      end else begin
         if (shadow_count == 0) begin
            res.status = bmhq_pkg::ST_EMPTY;
         end else begin
            res.min_value = bmhq_pkg::PRIO_BITS'(shadow_heap[0]);
            shadow_heap[0] = shadow_heap[shadow_count - 1];
            shadow_count--;
            pos = 0;
            sifting = 1'b1;
            while (sifting) begin
               left = 2 * pos + 1;
               if (left >= shadow_count) begin
                  sifting = 1'b0;
               end else begin
                  pick = left;
                  if (left + 1 < shadow_count && shadow_heap[left + 1] < shadow_heap[left])
                     pick = left + 1;
                  if (shadow_heap[pos] > shadow_heap[pick]) begin
                     tmp = shadow_heap[pos];
                     shadow_heap[pos] = shadow_heap[pick];
                     shadow_heap[pick] = tmp;
                     pos = pick;
                  end else begin
                     sifting = 1'b0;
                  end
               end
            end
            res.status = bmhq_pkg::ST_EXTRACTED;
         end
      end
      res.occupancy = bmhq_pkg::OCC_BITS'(shadow_count);
      status_tally[res.status]++;
      heap_results_due.push_back(res);
   endtask

   always @(posedge clock) begin : request_driver
      heap_request_type next_rq;
      bit               launch;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            apply_to_shadow_heap(heap_requests_pending.pop_front());
         end
         if (start && busy) begin
            launch = 1'b0;
         end else if (heap_requests_pending.size() == 0) begin
            start <= 1'b0;
         end else begin
            next_rq = heap_requests_pending[0];
            launch = 1'b1;
            if (next_rq.drain_first && heap_results_due.size() != 0) launch = 1'b0;
            if ($urandom_range(99) < next_rq.idle_pct) launch = 1'b0;
            if (launch) begin
               if (next_rq.drain_first) drain_pauses++;
               start            <= 1'b1;
               req_type         <= next_rq.kind;
               req_job_priority <= next_rq.value;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : result_check
      heap_result_type due;
      if (!reset && rsp_valid === 1'b1) begin
         if (heap_results_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: unexpected result min=%h status=%0d occupancy=%0d",
                        $realtime, rsp_min_value, rsp_status, rsp_occupancy);
         end else begin
            due = heap_results_due.pop_front();
            if (rsp_min_value !== due.min_value || rsp_status !== due.status ||
                rsp_occupancy !== due.occupancy) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: mismatch expected min=%h status=%0d occupancy=%0d, %s%h %s%0d %s%0d",
                           $realtime, due.min_value, due.status, due.occupancy,
                           "got min=", rsp_min_value, "status=", rsp_status,
                           "occupancy=", rsp_occupancy);
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int  idle_by_phase[3];
      int  mixed_items;
      int  seg_len;
      int  insert_pct;
      bit  first_of_phase;
      idle_by_phase = '{35, 49, 0};
      for (int ph = 0; ph < 3; ph++) begin
         gen_idle_pct = idle_by_phase[ph];
         first_of_phase = (ph != 0);
         if (ph == 0) begin
            add_request(bmhq_pkg::REQ_EXTRACT, 16'hFFFF, 1'b0);
            add_request(bmhq_pkg::REQ_INSERT, 16'hFFFF, 1'b0);
            add_request(bmhq_pkg::REQ_INSERT, 16'h0000, 1'b0);
            add_request(bmhq_pkg::REQ_INSERT, 16'h8000, 1'b0);
            add_request(bmhq_pkg::REQ_INSERT, 16'h7FFF, 1'b0);
            add_request(bmhq_pkg::REQ_INSERT, 16'h1234, 1'b0);
            add_request(bmhq_pkg::REQ_INSERT, 16'h1234, 1'b0);
            add_request(bmhq_pkg::REQ_INSERT, 16'h1234, 1'b0);
            add_request(bmhq_pkg::REQ_INSERT, 16'h0001, 1'b0);
            add_request(bmhq_pkg::REQ_INSERT, 16'hFFFE, 1'b0);
            repeat (10) add_request(bmhq_pkg::REQ_EXTRACT, 16'h5555, 1'b0);
         end
         while (gen_count < bmhq_pkg::HEAP_DEPTH) begin
            add_request(bmhq_pkg::REQ_INSERT, pick_value(), first_of_phase);
            first_of_phase = 1'b0;
         end
         repeat ($urandom_range(1, 3)) add_request(bmhq_pkg::REQ_INSERT, pick_value(), 1'b0);
         mixed_items = 0;
         while (mixed_items < 225) begin
            case ($urandom_range(2))
               0: insert_pct = 80;
               1: insert_pct = 20;
               default: insert_pct = 50;
            endcase
            seg_len = $urandom_range(20, 60);
            repeat (seg_len)
               add_request(($urandom_range(99) < insert_pct) ? bmhq_pkg::REQ_INSERT
                                                              : bmhq_pkg::REQ_EXTRACT,
                           pick_value(), $urandom_range(59) == 0);
            mixed_items += seg_len;
         end
         while (gen_count > 0)
            add_request(bmhq_pkg::REQ_EXTRACT, bmhq_pkg::PRIO_BITS'($urandom), 1'b0);
         repeat ($urandom_range(1, 2))
            add_request(bmhq_pkg::REQ_EXTRACT, bmhq_pkg::PRIO_BITS'($urandom), 1'b0);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (heap_requests_pending.size() != 0 || heap_results_due.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Covered %0d inserts, %0d extracts, %0d full rejects, %0d empty rejects.",
               status_tally[bmhq_pkg::ST_INSERTED], status_tally[bmhq_pkg::ST_EXTRACTED],
               status_tally[bmhq_pkg::ST_FULL], status_tally[bmhq_pkg::ST_EMPTY]);
      $display("Sender idled at 35, 49 and 0 percent and waited for the heap to settle %0d times.",
               drain_pauses);
      if (mismatch_count == 0 && heap_results_due.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// File: files.f
design/bmhq_pkg.sv
design/bmhq_ram.sv
design/bmhq_core.sv
design/binary_min_heap_queue_unit.sv
dv/tb_binary_min_heap_queue_unit.sv
